// ===== hdl/qgi_pkg.sv =====
// Shared constants, command/status types and mixing tables for the gyro integrator.
package qgi_pkg;

    localparam int QUAT_WIDTH_DEF = 32;
    localparam logic [31:0] HALF_DT_RESET = 32'd2147484;

    // register index, taken from paddr[2]
    localparam logic REG_HALF_DT = 1'b0;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_PMUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_PACC  = 4'd3;
    localparam logic [OP_W-1:0] OP_HMUL  = 4'd4;
    localparam logic [OP_W-1:0] OP_HADD  = 4'd5;
    localparam logic [OP_W-1:0] OP_SQMUL = 4'd6;
    localparam logic [OP_W-1:0] OP_SQACC = 4'd7;
    localparam logic [OP_W-1:0] OP_SQRT  = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd9;
    localparam logic [OP_W-1:0] OP_DIVWR = 4'd10;
    localparam logic [OP_W-1:0] OP_IDENT = 4'd11;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      row;
        logic [1:0]      col;
    } qgi_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic zero_norm;
        logic out_free;
    } qgi_stat_t;

    // which old component multiplies gyro axis col in row row
    function automatic logic [1:0] mix_idx(input logic [1:0] row, input logic [1:0] col);
        logic [1:0] r;
        case ({row, col})
            4'b00_00: r = 2'd1;
            4'b00_01: r = 2'd2;
            4'b00_10: r = 2'd3;
            4'b01_00: r = 2'd0;
            4'b01_01: r = 2'd3;
            4'b01_10: r = 2'd2;
            4'b10_00: r = 2'd3;
            4'b10_01: r = 2'd0;
            4'b10_10: r = 2'd1;
            4'b11_00: r = 2'd2;
            4'b11_01: r = 2'd1;
            4'b11_10: r = 2'd0;
            default:  r = 2'd0;
        endcase
        return r;
    endfunction

    // term is subtracted from the row sum
    function automatic logic mix_neg(input logic [1:0] row, input logic [1:0] col);
        logic r;
        case ({row, col})
            4'b00_00: r = 1'b1;
            4'b00_01: r = 1'b1;
            4'b00_10: r = 1'b1;
            4'b01_00: r = 1'b0;
            4'b01_01: r = 1'b1;
            4'b01_10: r = 1'b0;
            4'b10_00: r = 1'b0;
            4'b10_01: r = 1'b0;
            4'b10_10: r = 1'b1;
            4'b11_00: r = 1'b1;
            4'b11_01: r = 1'b0;
            4'b11_10: r = 1'b0;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/qgi_rate_if.sv =====
// Gyro sample channel: valid/ready with three signed Q16.16 rates.
interface qgi_rate_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

// ===== hdl/qgi_quat_if.sv =====
// Quaternion result channel: valid/ready with four signed Q1.30 components.
interface qgi_quat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                    input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                    output ready);
endinterface

// ===== hdl/quaternion_gyro_integrator.sv =====
// Top level of the quaternion gyro integrator: channels, half_dt register, control and datapath.
//
// Use: each beat on the gyro channel carries one three-axis rate sample (signed Q16.16,
// rad/s). The block advances its stored attitude quaternion by one first-order step
// scaled by half_dt, renormalizes it and sends one beat on the quat channel with the
// four components in signed Q1.30.
// Flow: one sample at a time. The shared multiplier has D = ceil(max(32, QUAT_WIDTH) / 8)
// digits and forms 20 products, one 8-bit digit a cycle; the serial square root and four
// divides follow, and the divides are skipped when the norm is zero. gyro.ready is high
// again in the same cycle that the result appears in the output register.
// Stall: a result waits in the output register while quat.ready is low; the next sample
// is taken meanwhile and its result waits until the register is free.
// Reset (rst_n low, asynchronous): attitude returns to identity (1, 0, 0, 0), half_dt to
// 2147484 (about 0.5 ms), both channels idle.
// Config: APB write of half_dt at address 0, only while no sample is in flight.
module quaternion_gyro_integrator #(
    parameter int QUAT_WIDTH = qgi_pkg::QUAT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qgi_rate_if.sink    gyro,
    qgi_quat_if.source  quat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qgi_pkg::*;

    logic [31:0] half_dt_reg;
    qgi_cmd_t    cmd;
    qgi_stat_t   stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_dt_reg <= HALF_DT_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_HALF_DT))
            half_dt_reg <= pwdata;
    end

    assign prdata = (paddr[2] == REG_HALF_DT) ? half_dt_reg : 32'd0;

    qgi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (gyro.valid),
        .in_ready (gyro.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qgi_dpath #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .half_dt   (half_dt_reg),
        .rate_x    (gyro.rate_x),
        .rate_y    (gyro.rate_y),
        .rate_z    (gyro.rate_z),
        .out_valid (quat.valid),
        .out_ready (quat.ready),
        .quat_w    (quat.quat_w),
        .quat_x    (quat.quat_x),
        .quat_y    (quat.quat_y),
        .quat_z    (quat.quat_z)
    );

endmodule

// ===== hdl/qgi_ctrl.sv =====
// Sequencer for the update, square-sum, square-root and divide phases.
module qgi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qgi_pkg::qgi_stat_t stat,
    output qgi_pkg::qgi_cmd_t  cmd
);
    import qgi_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PMUL   = 4'd1;
    localparam logic [3:0] S_PWAIT  = 4'd2;
    localparam logic [3:0] S_HMUL   = 4'd3;
    localparam logic [3:0] S_HWAIT  = 4'd4;
    localparam logic [3:0] S_SQMUL  = 4'd5;
    localparam logic [3:0] S_SQWAIT = 4'd6;
    localparam logic [3:0] S_SQRT   = 4'd7;
    localparam logic [3:0] S_SQRTW  = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_DIVW   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                cmd.op     = OP_PMUL;
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op = OP_PACC;
                    if (col_reg == 2'd2)
                    begin
                        col_next   = 2'd0;
                        state_next = S_HMUL;
                    end
                    else
                    begin
                        col_next   = col_reg + 2'd1;
                        state_next = S_PMUL;
                    end
                end
            end
            S_HMUL:
            begin
                cmd.op     = OP_HMUL;
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op   = OP_HADD;
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd3)
                        state_next = S_SQMUL;
                    else
                        state_next = S_PMUL;
                end
            end
            S_SQMUL:
            begin
                cmd.op     = OP_SQMUL;
                state_next = S_SQWAIT;
            end
            S_SQWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op   = OP_SQACC;
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd3)
                        state_next = S_SQRT;
                    else
                        state_next = S_SQMUL;
                end
            end
            S_SQRT:
            begin
                cmd.op     = OP_SQRT;
                state_next = S_SQRTW;
            end
            S_SQRTW:
            begin
                if (stat.sqrt_done)
                begin
                    if (stat.zero_norm)
                    begin
                        cmd.op     = OP_IDENT;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.op     = OP_DIV;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.op   = OP_DIVWR;
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd3)
                        state_next = S_OUT;
                    else
                        state_next = S_DIV;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/qgi_dpath.sv =====
// Datapath: attitude registers, shared digit-serial multiplier, square root and divider.
module qgi_dpath #(
    parameter int QUAT_WIDTH = qgi_pkg::QUAT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  qgi_pkg::qgi_cmd_t  cmd,
    output qgi_pkg::qgi_stat_t stat,
    input  logic [31:0]        half_dt,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z
);
    import qgi_pkg::*;

    localparam int QW     = QUAT_WIDTH;
    localparam int FRAC   = QW - 2;
    localparam int TW     = 62;                      // clamped term magnitude
    localparam int MB_RAW = (QW > 32) ? QW : 32;
    localparam int MB     = ((MB_RAW + 7) / 8) * 8;  // multiplier b operand
    localparam int NDIG   = MB / 8;
    localparam int PW     = TW + MB;
    localparam int MCW    = $clog2(NDIG + 1);
    localparam int N2W    = QW + 3;
    localparam int RTW    = QW + 2;
    localparam int RMW    = QW + 4;
    localparam int RADW   = 2 * RTW;
    localparam int SCW    = $clog2(RTW + 1);
    localparam int DCW    = $clog2(QW + 1);
    localparam int UP     = (QW < 32) ? 32 - QW : 0;
    localparam int DN     = (QW > 32) ? QW - 32 : 0;

    localparam logic [PW-1:0]     LIM_P  = {{(PW-TW){1'b0}}, 1'b1, {(TW-1){1'b0}}};
    localparam logic signed [63:0] LIM64 = 64'sd1 <<< 61;
    localparam logic signed [63:0] QMAX64 = (64'sd1 <<< (QW - 1)) - 64'sd1;
    localparam logic signed [63:0] QMIN64 = -(64'sd1 <<< (QW - 1));
    localparam logic [QW-1:0] QMAX_Q = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] QMIN_Q = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] ONE_Q  = {2'b01, {FRAC{1'b0}}};

    function automatic logic [31:0] to_q30(input logic [QW-1:0] v);
        logic signed [QW+31:0] wide;
        wide = $signed({{32{v[QW-1]}}, v});
        wide = wide <<< UP;
        wide = wide >>> DN;
        return wide[31:0];
    endfunction

    logic signed [31:0]   g_reg [4];
    logic [QW-1:0]        att_reg [4];
    logic [QW-1:0]        nq_reg [4];
    logic signed [63:0]   sum_reg;
    logic [N2W-1:0]       n2_reg;
    logic                 p_neg_reg;

    logic [PW-1:0]        a_sh_reg;
    logic [MB-1:0]        b_sh_reg;
    logic [PW-1:0]        prod_reg;
    logic [MCW-1:0]       mcnt_reg;
    logic                 mbusy_reg;

    logic [RADW-1:0]      rad_reg;
    logic [RMW-1:0]       rem_reg;
    logic [RTW-1:0]       root_reg;
    logic [SCW-1:0]       scnt_reg;
    logic                 sbusy_reg;

    logic [RTW-1:0]       drem_reg;
    logic [QW-1:0]        dlow_reg;
    logic [QW-1:0]        q_reg;
    logic                 ovf_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic                 dbusy_reg;

    logic                 out_valid_reg;
    logic [31:0]          ow_reg, ox_reg, oy_reg, oz_reg;

    // read ports
    logic [1:0]           att_sel;
    logic [QW-1:0]        att_rd, nq_rd, att_mag, nq_mag;
    logic signed [31:0]   g_rd;
    logic [31:0]          g_mag;

    logic signed [63:0]   sum_cl, sum_abs;
    logic [TW-1:0]        sum_mag;
    logic [PW-1:0]        tsh, dsh, sqsh;
    logic [TW-1:0]        term, dval;
    logic signed [63:0]   term_s, dsig, upd64, upd_sat;

    logic [PW+7:0]        pp;
    logic [RMW-1:0]       s_rs, s_trial;
    logic                 s_ge;
    logic [RTW-1:0]       d_rs;
    logic                 d_ge;
    logic [QW-1:0]        d_hi, q_fin, q_sat;

    logic                 mul_start;
    logic [PW-1:0]        mul_a;
    logic [MB-1:0]        mul_b;
    logic                 mul_neg;

    assign att_sel = (cmd.op == OP_PMUL) ? mix_idx(cmd.row, cmd.col) : cmd.row;
    assign att_rd  = att_reg[att_sel];
    assign nq_rd   = nq_reg[cmd.row];
    assign g_rd    = g_reg[cmd.col];
    assign att_mag = att_rd[QW-1] ? (~att_rd + 1'b1) : att_rd;
    assign nq_mag  = nq_rd[QW-1] ? (~nq_rd + 1'b1) : nq_rd;
    assign g_mag   = g_rd[31] ? (~g_rd + 1'b1) : g_rd;

    always_comb
    begin
        if (sum_reg > LIM64)
            sum_cl = LIM64;
        else if (sum_reg < -LIM64)
            sum_cl = -LIM64;
        else
            sum_cl = sum_reg;
        sum_abs = sum_cl[63] ? -sum_cl : sum_cl;
        sum_mag = sum_abs[TW-1:0];
    end

    // product post-processing: truncate toward zero on magnitudes, clamp to 2^61
    assign tsh    = prod_reg >> 16;
    assign dsh    = prod_reg >> 32;
    assign sqsh   = prod_reg >> FRAC;
    assign term   = (tsh > LIM_P) ? LIM_P[TW-1:0] : tsh[TW-1:0];
    assign dval   = (dsh > LIM_P) ? LIM_P[TW-1:0] : dsh[TW-1:0];
    assign term_s = $signed({2'b00, term});
    assign dsig   = p_neg_reg ? -$signed({2'b00, dval}) : $signed({2'b00, dval});
    assign upd64  = $signed({{(64-QW){att_rd[QW-1]}}, att_rd}) + dsig;

    always_comb
    begin
        if (upd64 > QMAX64)
            upd_sat = QMAX64;
        else if (upd64 < QMIN64)
            upd_sat = QMIN64;
        else
            upd_sat = upd64;
    end

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        case (cmd.op)
            OP_PMUL:
            begin
                mul_start = 1'b1;
                mul_a     = PW'(att_mag);
                mul_b     = MB'(g_mag);
                mul_neg   = mix_neg(cmd.row, cmd.col) ^ att_rd[QW-1] ^ g_rd[31];
            end
            OP_HMUL:
            begin
                mul_start = 1'b1;
                mul_a     = PW'(sum_mag);
                mul_b     = MB'(half_dt);
                mul_neg   = sum_cl[63];
            end
            OP_SQMUL:
            begin
                mul_start = 1'b1;
                mul_a     = PW'(nq_mag);
                mul_b     = MB'(nq_mag);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // one 8-bit digit of b per cycle
    assign pp = {8'd0, a_sh_reg} * {{PW{1'b0}}, b_sh_reg[7:0]};

    // square root: two radicand bits per step
    assign s_rs    = {rem_reg[RMW-3:0], rad_reg[RADW-1 -: 2]};
    assign s_trial = {root_reg, 2'b01};
    assign s_ge    = (s_rs >= s_trial);

    // restoring divide by the norm, one quotient bit per step
    assign d_rs  = {drem_reg[RTW-2:0], dlow_reg[QW-1]};
    assign d_ge  = (d_rs >= root_reg);
    assign d_hi  = nq_mag >> 2;
    assign q_fin = ovf_reg ? {QW{1'b1}} : q_reg;

    always_comb
    begin
        if (!nq_rd[QW-1])
            q_sat = q_fin[QW-1] ? QMAX_Q : q_fin;
        else
            q_sat = q_fin[QW-1] ? QMIN_Q : (~q_fin + 1'b1);
    end

    // control state and attitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg     <= 1'b0;
            mcnt_reg      <= '0;
            sbusy_reg     <= 1'b0;
            scnt_reg      <= '0;
            dbusy_reg     <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            att_reg[0]    <= ONE_Q;
            att_reg[1]    <= '0;
            att_reg[2]    <= '0;
            att_reg[3]    <= '0;
        end
        else
        begin
            if (mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= MCW'(NDIG);
            end
            else if (mbusy_reg)
            begin
                if (mcnt_reg == '0)
                    mbusy_reg <= 1'b0;
                else
                    mcnt_reg <= mcnt_reg - 1'b1;
            end

            if (cmd.op == OP_SQRT)
            begin
                sbusy_reg <= 1'b1;
                scnt_reg  <= SCW'(RTW);
            end
            else if (sbusy_reg)
            begin
                if (scnt_reg == '0)
                    sbusy_reg <= 1'b0;
                else
                    scnt_reg <= scnt_reg - 1'b1;
            end

            if (cmd.op == OP_DIV)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= DCW'(QW);
            end
            else if (dbusy_reg)
            begin
                if (dcnt_reg == '0)
                    dbusy_reg <= 1'b0;
                else
                    dcnt_reg <= dcnt_reg - 1'b1;
            end

            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.op == OP_IDENT)
            begin
                att_reg[0] <= ONE_Q;
                att_reg[1] <= '0;
                att_reg[2] <= '0;
                att_reg[3] <= '0;
            end
            else if (cmd.op == OP_DIVWR)
            begin
                att_reg[cmd.row] <= q_sat;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            g_reg[0] <= rate_x;
            g_reg[1] <= rate_y;
            g_reg[2] <= rate_z;
            g_reg[3] <= rate_z;
            sum_reg  <= '0;
            n2_reg   <= '0;
        end
        else if (cmd.op == OP_PACC)
        begin
            sum_reg <= p_neg_reg ? (sum_reg - term_s) : (sum_reg + term_s);
        end
        else if (cmd.op == OP_HADD)
        begin
            nq_reg[cmd.row] <= upd_sat[QW-1:0];
            sum_reg         <= '0;
        end
        else if (cmd.op == OP_SQACC)
        begin
            n2_reg <= n2_reg + sqsh[N2W-1:0];
        end

        if (mul_start)
        begin
            a_sh_reg  <= mul_a;
            b_sh_reg  <= mul_b;
            prod_reg  <= '0;
            p_neg_reg <= mul_neg;
        end
        else if (mbusy_reg && (mcnt_reg != '0))
        begin
            prod_reg <= prod_reg + pp[PW-1:0];
            a_sh_reg <= a_sh_reg << 8;
            b_sh_reg <= b_sh_reg >> 8;
        end

        if (cmd.op == OP_SQRT)
        begin
            rad_reg  <= RADW'({n2_reg, {FRAC{1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (sbusy_reg && (scnt_reg != '0))
        begin
            rem_reg  <= s_ge ? (s_rs - s_trial) : s_rs;
            root_reg <= {root_reg[RTW-2:0], s_ge};
            rad_reg  <= rad_reg << 2;
        end

        if (cmd.op == OP_DIV)
        begin
            drem_reg <= RTW'(d_hi);
            dlow_reg <= {nq_mag[1:0], {FRAC{1'b0}}};
            q_reg    <= '0;
            ovf_reg  <= (RTW'(d_hi) >= root_reg);
        end
        else if (dbusy_reg && (dcnt_reg != '0))
        begin
            drem_reg <= d_ge ? (d_rs - root_reg) : d_rs;
            q_reg    <= {q_reg[QW-2:0], d_ge};
            dlow_reg <= dlow_reg << 1;
        end

        if (cmd.op == OP_OUT)
        begin
            ow_reg <= to_q30(att_reg[0]);
            ox_reg <= to_q30(att_reg[1]);
            oy_reg <= to_q30(att_reg[2]);
            oz_reg <= to_q30(att_reg[3]);
        end
    end

    assign stat.mul_done  = mbusy_reg && (mcnt_reg == '0);
    assign stat.sqrt_done = sbusy_reg && (scnt_reg == '0);
    assign stat.div_done  = dbusy_reg && (dcnt_reg == '0);
    assign stat.zero_norm = (root_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign quat_w    = ow_reg;
    assign quat_x    = ox_reg;
    assign quat_y    = oy_reg;
    assign quat_z    = oz_reg;

endmodule

// ===== hdl/qgi_checker.sv =====
// Port-level assertions for the gyro integrator and the bind that attaches them.
module qgi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_w,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z
);

    // a result beat stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("quat valid dropped while stalled");

    // payload of a stalled result beat does not move
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_w, out_x, out_y, out_z}))
        else $error("quat payload changed while stalled");

    // one sample at a time: no new beat taken right after one is accepted
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("gyro ready high right after accept");

    // a result is never produced in the cycle after a sample is taken
    a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // when a fresh result appears the sequencer is back at idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while sample still in flight");

endmodule

bind quaternion_gyro_integrator qgi_checker u_qgi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gyro.valid),
    .in_ready  (gyro.ready),
    .out_valid (quat.valid),
    .out_ready (quat.ready),
    .out_w     (quat.quat_w),
    .out_x     (quat.quat_x),
    .out_y     (quat.quat_y),
    .out_z     (quat.quat_z)
);

// ===== verif/quaternion_gyro_integrator_test.sv =====
// Testbench for quaternion_gyro_integrator: directed and random gyro beats against a predictor.
`timescale 1ns / 100ps

module quaternion_gyro_integrator_test;
    import qgi_pkg::*;

    localparam logic signed [63:0] Q_ONE     = 64'sd1 <<< 30;
    localparam logic signed [63:0] Q_MAX     = (64'sd1 <<< 31) - 1;
    localparam logic signed [63:0] Q_MIN     = -(64'sd1 <<< 31);
    localparam logic [127:0]       SUM_LIM   = 128'd1 << 61;
    localparam longint             CYCLE_LIM = 1500000;
    localparam int                 LATENCY   = 294;

    typedef struct {
        logic [31:0] w;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } quat_beat_t;

    // old component used by each row/axis product, and whether it is subtracted
    localparam int ROW_SRC [4][3] = '{'{1, 2, 3}, '{0, 3, 2}, '{3, 0, 1}, '{2, 1, 0}};
    localparam bit ROW_SUB [4][3] = '{'{1, 1, 1}, '{0, 1, 0}, '{0, 0, 1}, '{1, 0, 0}};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qgi_rate_if gyro ();
    qgi_quat_if quat ();

    quaternion_gyro_integrator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .gyro    (gyro.sink),
        .quat    (quat.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic signed [63:0] attitude [4];
    logic [31:0]        half_dt;
    quat_beat_t         pending_quats [$];
    int                 mismatches;
    longint             cycles;
    bit                 quiet;
    bit                 hold_quat;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIM)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // a*b >> sh, truncated toward zero, magnitude clamped to 2^61
    function automatic logic signed [63:0] mul_shift(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] m;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        m = ({64'd0, ua} * {64'd0, ub}) >> sh;
        if (m > SUM_LIM)
            m = SUM_LIM;
        return ((a < 0) != (b < 0)) ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        return v < Q_MIN ? Q_MIN : (v > Q_MAX ? Q_MAX : v);
    endfunction

    function automatic quat_beat_t integrate(input logic signed [31:0] rx,
                                             input logic signed [31:0] ry,
                                             input logic signed [31:0] rz);
        logic signed [63:0] g [3];
        logic signed [63:0] old [4];
        logic signed [63:0] sum;
        logic signed [63:0] t;
        logic [63:0]        mag;
        logic [127:0]       n2;
        logic [127:0]       root;
        logic [127:0]       trial;
        logic [127:0]       quo;
        quat_beat_t         r;
        g[0] = rx;
        g[1] = ry;
        g[2] = rz;
        old = attitude;
        for (int row = 0; row < 4; row++)
        begin
            sum = 0;
            for (int ax = 0; ax < 3; ax++)
            begin
                t = mul_shift(old[ROW_SRC[row][ax]], g[ax], 16);
                sum = ROW_SUB[row][ax] ? sum - t : sum + t;
            end
            if (sum > $signed(SUM_LIM[63:0]))
                sum = SUM_LIM[63:0];
            if (sum < -$signed(SUM_LIM[63:0]))
                sum = -$signed(SUM_LIM[63:0]);
            attitude[row] = clamp_q(old[row] + mul_shift(sum, {32'd0, half_dt}, 32));
        end
        // renormalize: n2 = sum of floor(c^2 / 2^30), root = isqrt(n2 * 2^30)
        n2 = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag = attitude[i] < 0 ? -attitude[i] : attitude[i];
            n2 += ({64'd0, mag} * {64'd0, mag}) >> 30;
        end
        root = 0;
        for (int b = 33; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= (n2 << 30))
                root = trial;
        end
        if (root == 0)
        begin
            attitude[0] = Q_ONE;
            attitude[1] = 0;
            attitude[2] = 0;
            attitude[3] = 0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag = attitude[i] < 0 ? -attitude[i] : attitude[i];
                quo = ({64'd0, mag} << 30) / root;
                if (quo > 128'hFFFF_FFFF)
                    quo = 128'hFFFF_FFFF;
                attitude[i] = clamp_q(attitude[i] < 0 ? -$signed(quo[63:0])
                                                      : $signed(quo[63:0]));
            end
        end
        r.w = attitude[0][31:0];
        r.x = attitude[1][31:0];
        r.y = attitude[2][31:0];
        r.z = attitude[3][31:0];
        return r;
    endfunction

    task automatic write_half_dt(input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_HALF_DT, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        half_dt = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // valid stays high after the beat; gap() sometimes lowers it, drain() always does
    task automatic send_rate(input logic [31:0] rx, input logic [31:0] ry, input logic [31:0] rz);
        @(negedge clk);
        gyro.valid  = 1'b1;
        gyro.rate_x = rx;
        gyro.rate_y = ry;
        gyro.rate_z = rz;
        do @(posedge clk); while (!gyro.ready);
        pending_quats.push_back(integrate(rx, ry, rz));
    endtask

    task automatic gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            gyro.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        gyro.valid = 1'b0;
        wait (pending_quats.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] corner [6];
        corner = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                   32'hFFFF_0000};
        send_rate(0, 0, 0);
        for (int a = 0; a < 6; a++)
        begin
            send_rate(corner[a], 0, 0);
            send_rate(0, corner[a], 0);
            send_rate(0, 0, corner[a]);
            gap();
        end
        drain();
    endtask

    task automatic test_half_dt_corners();
        write_half_dt(32'h0);
        send_rate(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        // huge steps: components saturate before renormalization
        write_half_dt(32'hFFFF_FFFF);
        send_rate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_rate(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_rate(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_rate(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555);
        drain();
    endtask

    task automatic test_backpressure();
        write_half_dt(HALF_DT_RESET);
        fork
            begin
                hold_quat = 1'b1;
                repeat (1500) @(posedge clk);
                hold_quat = 1'b0;
            end
            repeat (12) send_rate(pick_rate(), pick_rate(), pick_rate());
        join
        drain();
    endtask

    task automatic test_random(input int count, input logic [31:0] step);
        write_half_dt(step);
        repeat (count)
        begin
            send_rate(pick_rate(), pick_rate(), pick_rate());
            gap();
        end
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        quat_beat_t e;
        if (rst_n && quat.valid && quat.ready)
        begin
            if (pending_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quat beat %h %h %h %h", quat.quat_w, quat.quat_x,
                             quat.quat_y, quat.quat_z);
            end
            else
            begin
                e = pending_quats.pop_front();
                if (quat.quat_w !== e.w || quat.quat_x !== e.x ||
                    quat.quat_y !== e.y || quat.quat_z !== e.z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("quat mismatch: exp %h %h %h %h got %h %h %h %h",
                                 e.w, e.x, e.y, e.z, quat.quat_w, quat.quat_x,
                                 quat.quat_y, quat.quat_z);
                end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        quat.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_quat)
                quat.ready = 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                quat.ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end
            else
                quat.ready = 1'b1;
        end
    end

    initial
    begin
        cycles      = 0;
        mismatches  = 0;
        quiet       = 1'b0;
        hold_quat   = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        gyro.valid  = 1'b0;
        gyro.rate_x = '0;
        gyro.rate_y = '0;
        gyro.rate_z = '0;
        half_dt     = HALF_DT_RESET;
        attitude    = '{Q_ONE, 64'sd0, 64'sd0, 64'sd0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_half_dt_corners();
        test_backpressure();
        test_random(150, HALF_DT_RESET);
        test_random(120, $urandom());
        test_random(120, $urandom_range(0, 1 << 24));
        test_random(100, 32'hFFFF_FFFF);
        quiet = 1'b1;
        test_random(150, $urandom_range(1 << 16, 1 << 22));

        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_quats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
